>>> hw/rtl/dhcp_option_parser_core_defines.svh
// Assertion macros shared by the option parser RTL.
`ifndef DHCP_OPTION_PARSER_CORE_DEFINES_SVH
`define DHCP_OPTION_PARSER_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define DOP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dop assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define DOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dop assertion failed: next-cycle implication");

`endif

>>> hw/rtl/dop_pkg.sv
package dop_pkg;

  // Option codes of interest
  localparam logic [7:0] CODE_PAD       = 8'd0;
  localparam logic [7:0] CODE_SUBNET    = 8'd1;
  localparam logic [7:0] CODE_ROUTER    = 8'd3;
  localparam logic [7:0] CODE_DNS       = 8'd6;
  localparam logic [7:0] CODE_REQ_ADDR  = 8'd50;
  localparam logic [7:0] CODE_LEASE     = 8'd51;
  localparam logic [7:0] CODE_MSG_TYPE  = 8'd53;
  localparam logic [7:0] CODE_SERVER_ID = 8'd54;
  localparam logic [7:0] CODE_END       = 8'd255;

  // Capture slots
  localparam int unsigned NUM_SLOTS = 6;
  localparam logic [2:0] SLOT_SUBNET    = 3'd0;
  localparam logic [2:0] SLOT_ROUTER    = 3'd1;
  localparam logic [2:0] SLOT_DNS       = 3'd2;
  localparam logic [2:0] SLOT_SERVER_ID = 3'd3;
  localparam logic [2:0] SLOT_LEASE     = 3'd4;
  localparam logic [2:0] SLOT_REQ_ADDR  = 3'd5;
  localparam logic [2:0] SLOT_NONE      = 3'd6;

  // Most value bytes kept per option
  localparam logic [2:0] MAX_KEEP = 3'd4;

  // Parse phase of the front end
  typedef enum logic [2:0] {
    PH_CODE  = 3'b001,
    PH_LEN   = 3'b010,
    PH_VALUE = 3'b100
  } phase_e;

  // One classified byte, front to back
  typedef struct packed {
    logic [7:0] opt_val;    // the byte itself
    logic       clr_sw;     // clear the shift word (length byte)
    logic       shift;      // shift the byte into the shift word
    logic       take_type;  // first value byte of the message type option
    logic       finish;     // option complete: store the shift word
    logic [2:0] slot;       // capture slot of the current option
    logic [2:0] nbytes;     // value bytes held in the shift word
    logic       emit;       // give a result after this byte
    logic       end_seen;
    logic       trunc;
    logic       last;       // final byte of the packet
  } evt_t;

  function automatic logic [2:0] slot_of(input logic [7:0] code);
    logic [2:0] s;
    case (code)
      CODE_SUBNET:    s = SLOT_SUBNET;
      CODE_ROUTER:    s = SLOT_ROUTER;
      CODE_DNS:       s = SLOT_DNS;
      CODE_SERVER_ID: s = SLOT_SERVER_ID;
      CODE_LEASE:     s = SLOT_LEASE;
      CODE_REQ_ADDR:  s = SLOT_REQ_ADDR;
      default:        s = SLOT_NONE;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/dop_front.sv
`include "dhcp_option_parser_core_defines.svh"

module dop_front import dop_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] opt_byte_i,
  input  logic       last_byte_i,
  output evt_t       evt_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] cur_code_q, cur_code_d;
  logic [7:0] rem_q, rem_d;
  logic [2:0] vidx_q, vidx_d;
  logic       done_q, done_d;
  evt_t       evt;

  // Walk code, length and value fields for one byte
  always_comb begin
    phase_d    = phase_q;
    cur_code_d = cur_code_q;
    rem_d      = rem_q;
    vidx_d     = vidx_q;
    done_d     = done_q;
    evt          = '0;
    evt.opt_val  = opt_byte_i;
    evt.last     = last_byte_i;
    evt.slot     = slot_of(cur_code_q);

    if (!done_q) begin
      case (phase_q)
        PH_LEN: begin
          rem_d      = opt_byte_i;
          vidx_d     = 3'd0;
          evt.clr_sw = 1'b1;
          if (opt_byte_i == 8'd0) begin
            evt.finish = 1'b1;
            evt.nbytes = 3'd0;
            phase_d    = PH_CODE;
          end else begin
            phase_d = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (cur_code_q == CODE_MSG_TYPE && vidx_q == 3'd0) begin
            evt.take_type = 1'b1;
          end
          if (vidx_q < MAX_KEEP) begin
            evt.shift = 1'b1;
            vidx_d    = vidx_q + 3'd1;
          end
          rem_d = rem_q - 8'd1;
          if (rem_d == 8'd0) begin
            evt.finish = 1'b1;
            evt.nbytes = vidx_d;
            phase_d    = PH_CODE;
          end
        end
        default: begin
          phase_d = PH_CODE;
          if (opt_byte_i == CODE_END) begin
            done_d       = 1'b1;
            evt.emit     = 1'b1;
            evt.end_seen = 1'b1;
          end else if (opt_byte_i != CODE_PAD) begin
            cur_code_d = opt_byte_i;
            phase_d    = PH_LEN;
          end
        end
      endcase
      if (last_byte_i && !evt.emit) begin
        evt.emit  = 1'b1;
        evt.trunc = (phase_d != PH_CODE);
      end
    end

    // Return to the packet-start state after the final byte
    if (last_byte_i) begin
      phase_d    = PH_CODE;
      cur_code_d = 8'd0;
      rem_d      = 8'd0;
      vidx_d     = 3'd0;
      done_d     = 1'b0;
    end
  end

  assign evt_o = evt;

  // Advance parse state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CODE;
      cur_code_q <= 8'd0;
      rem_q      <= 8'd0;
      vidx_q     <= 3'd0;
      done_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      cur_code_q <= cur_code_d;
      rem_q      <= rem_d;
      vidx_q     <= vidx_d;
      done_q     <= done_d;
    end
  end

  `DOP_ASSERT_NOW(a_done_in_code, clk_i, rst_ni, done_q, phase_q == PH_CODE)
  `DOP_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, accept_i && last_byte_i,
                   !done_q && phase_q == PH_CODE && vidx_q == 3'd0)

endmodule

>>> hw/rtl/dop_queue.sv
`include "dhcp_option_parser_core_defines.svh"

module dop_queue import dop_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  evt_t push_evt_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output evt_t pop_evt_o
);

  evt_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == 2'd2);
  assign avail_o   = (cnt_q != 2'd0);
  assign pop_evt_o = mem_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_evt_i;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  `DOP_ASSERT_NOW(a_ptr_level, clk_i, rst_ni, cnt_q == 2'd0 || cnt_q == 2'd2,
                  wr_ptr_q == rd_ptr_q)

endmodule

>>> hw/rtl/dop_back.sv
`include "dhcp_option_parser_core_defines.svh"

module dop_back import dop_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  evt_t        evt_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  msg_type_o,
  output logic [31:0] net_mask_o,
  output logic [31:0] router_addr_o,
  output logic [31:0] dns_addr_o,
  output logic [31:0] server_ident_o,
  output logic [31:0] lease_seconds_o,
  output logic [31:0] requested_addr_o,
  output logic        end_seen_o,
  output logic        truncated_o
);

  logic [31:0] sw_q, sw_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] cap_q [NUM_SLOTS];
  logic [31:0] cap_d [NUM_SLOTS];
  logic [31:0] aligned;
  logic        out_valid_q;
  logic [7:0]  out_type_q;
  logic [31:0] out_cap_q [NUM_SLOTS];
  logic        out_end_q, out_trunc_q;
  logic        out_free;

  // Take an event unless it emits into an occupied output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = avail_i && (!evt_i.emit || out_free);

  // Shift word and message type after this event
  always_comb begin
    sw_d = sw_q;
    if (evt_i.clr_sw) begin
      sw_d = 32'd0;
    end else if (evt_i.shift) begin
      sw_d = {sw_q[23:0], evt_i.opt_val};
    end
    type_d = evt_i.take_type ? evt_i.opt_val : type_q;
  end

  // Move the held bytes to the top of the word
  always_comb begin
    case (evt_i.nbytes)
      3'd0:    aligned = 32'd0;
      3'd1:    aligned = {sw_d[7:0], 24'd0};
      3'd2:    aligned = {sw_d[15:0], 16'd0};
      3'd3:    aligned = {sw_d[23:0], 8'd0};
      default: aligned = sw_d;
    endcase
  end

  // Store a finished option into its slot
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cap_d[i] = cap_q[i];
      if (evt_i.finish && evt_i.slot == i[2:0]) begin
        cap_d[i] = aligned;
      end
    end
  end

  // Parse-side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= 32'd0;
      type_q <= 8'd0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cap_q[i] <= 32'd0;
      end
    end else if (pop_o) begin
      sw_q   <= evt_i.last ? 32'd0 : sw_d;
      type_q <= evt_i.last ? 8'd0 : type_d;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cap_q[i] <= cap_d[i];
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pop_o && evt_i.emit;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (out_free && pop_o && evt_i.emit) begin
      out_type_q  <= type_d;
      out_end_q   <= evt_i.end_seen;
      out_trunc_q <= evt_i.trunc;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        out_cap_q[i] <= cap_d[i];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign msg_type_o       = out_type_q;
  assign net_mask_o       = out_cap_q[SLOT_SUBNET];
  assign router_addr_o    = out_cap_q[SLOT_ROUTER];
  assign dns_addr_o       = out_cap_q[SLOT_DNS];
  assign server_ident_o   = out_cap_q[SLOT_SERVER_ID];
  assign lease_seconds_o  = out_cap_q[SLOT_LEASE];
  assign requested_addr_o = out_cap_q[SLOT_REQ_ADDR];
  assign end_seen_o       = out_end_q;
  assign truncated_o      = out_trunc_q;

  `DOP_ASSERT_NOW(a_flags_exclusive, clk_i, rst_ni, out_valid_q,
                  !(out_end_q && out_trunc_q))

endmodule

>>> hw/rtl/dhcp_option_parser_core.sv
// DHCP options parser: takes the options area one byte per transfer (last_byte_i marks the
// final byte) and gives one result per packet, on the end code or on the final byte. It
// sustains one byte per clock cycle while in_stall_o is low; a result is registered in the
// two-entry queue and then in the output register before it is presented. The queue sits
// between the byte classifier and the capture stage, so input stall rises only when that
// queue fills while the output is held by out_stall_i. Captured option values persist
// from packet to packet; the message type clears at each packet start.
module dhcp_option_parser_core import dop_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  opt_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  msg_type_o,
  output logic [31:0] net_mask_o,
  output logic [31:0] router_addr_o,
  output logic [31:0] dns_addr_o,
  output logic [31:0] server_ident_o,
  output logic [31:0] lease_seconds_o,
  output logic [31:0] requested_addr_o,
  output logic        end_seen_o,
  output logic        truncated_o
);

  logic accept;
  logic q_full, q_avail, q_pop;
  evt_t push_evt, pop_evt;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Classify bytes
  dop_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opt_byte_i  (opt_byte_i),
    .last_byte_i (last_byte_i),
    .evt_o       (push_evt)
  );

  // Decouple front and back
  dop_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_evt_i (push_evt),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .avail_o    (q_avail),
    .pop_evt_o  (pop_evt)
  );

  // Capture values and build results
  dop_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .avail_i          (q_avail),
    .evt_i            (pop_evt),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .msg_type_o       (msg_type_o),
    .net_mask_o       (net_mask_o),
    .router_addr_o    (router_addr_o),
    .dns_addr_o       (dns_addr_o),
    .server_ident_o   (server_ident_o),
    .lease_seconds_o  (lease_seconds_o),
    .requested_addr_o (requested_addr_o),
    .end_seen_o       (end_seen_o),
    .truncated_o      (truncated_o)
  );

endmodule
